/* hdl/sadpcm_pkg.sv */
// Shared types, constants and the filter coefficient table of the ADPCM block decoder.
// Used by sadpcm_filter_unit, spu_adpcm_block_decoder and its checker; no dependencies.
package sadpcm_pkg;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 8;
  localparam int unsigned PROD_W     = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W      = 20;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned COEF_SHIFT = 6;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic CFG_IDX_OUTPUT_ENABLE = 1'b0;
  localparam logic CFG_IDX_IGNORE_LOOP   = 1'b1;

  // Positions within a 16-byte block
  localparam logic [3:0] POS_HEADER = 4'd0;
  localparam logic [3:0] POS_FLAGS  = 4'd1;
  localparam logic [3:0] POS_LAST   = 4'd15;

  // Filter numbers and block flags
  localparam logic [3:0] FILTER_MAX      = 4'd4;
  localparam int unsigned FLAG_LOOP_MARK = 2;
  localparam int unsigned FLAG_END       = 0;
  localparam logic [7:0] FLAGS_LOOP      = 8'h03;

  // End action codes reported on the last beat of a block
  localparam logic [1:0] END_CONTINUE = 2'd0;
  localparam logic [1:0] END_STOP     = 2'd1;
  localparam logic [1:0] END_LOOP     = 2'd2;

  // Control from the sequencer to the shared filter unit
  typedef struct packed {
    logic load;     // first half of a nibble: nibble term plus newest history term
    logic nib_hi;   // take the high nibble of the byte
  } unit_ctrl_t;

  // Coefficient for a filter; sel 0 weighs the newest history, sel 1 the older one.
  function automatic logic signed [COEF_W-1:0] filter_coef(input logic [3:0] filter,
                                                          input logic sel);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case (filter)
      4'd1: c = sel ? 8'sd0 : 8'sd60;
      4'd2: c = sel ? -8'sd52 : 8'sd115;
      4'd3: c = sel ? -8'sd55 : 8'sd98;
      4'd4: c = sel ? -8'sd60 : 8'sd122;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* hdl/sadpcm_filter_unit.sv */
// Shared multiply-accumulate unit that reconstructs one ADPCM sample in two passes.
// Depends on sadpcm_pkg for widths, the control struct and the coefficient table.
module sadpcm_filter_unit (
  input  logic                                    clk_i,
  input  sadpcm_pkg::unit_ctrl_t                  ctrl_i,
  input  logic [7:0]                              byte_i,
  input  logic [3:0]                              shift_i,
  input  logic [3:0]                              filter_i,
  input  logic signed [sadpcm_pkg::SAMPLE_W-1:0]  hist_one_i,
  input  logic signed [sadpcm_pkg::SAMPLE_W-1:0]  hist_two_i,
  output logic signed [sadpcm_pkg::SAMPLE_W-1:0]  result_o
);

  localparam int unsigned AW = sadpcm_pkg::ACC_W;
  localparam logic signed [AW-1:0] SAT_MAX = AW'(32767);
  localparam logic signed [AW-1:0] SAT_MIN = -AW'(32768);

  logic [sadpcm_pkg::NIB_W-1:0]            nibble;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0]  nib_placed;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0]  nib_shifted;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0]  hist_sel;
  logic signed [sadpcm_pkg::COEF_W-1:0]    coef_sel;
  logic signed [sadpcm_pkg::PROD_W-1:0]    prod;
  logic signed [sadpcm_pkg::PROD_W-1:0]    prod_scaled;
  logic signed [AW-1:0]                    term;
  logic signed [AW-1:0]                    sum;
  logic signed [AW-1:0]                    acc_q;

  // Nibble placed in the top bits and shifted down arithmetically.
  assign nibble      = ctrl_i.nib_hi ? byte_i[7:4] : byte_i[3:0];
  assign nib_placed  = {nibble, {(sadpcm_pkg::SAMPLE_W - sadpcm_pkg::NIB_W){1'b0}}};
  assign nib_shifted = nib_placed >>> shift_i;

  // The one multiplier: newest history on the load pass, older history on the finish pass.
  assign hist_sel    = ctrl_i.load ? hist_one_i : hist_two_i;
  assign coef_sel    = sadpcm_pkg::filter_coef(filter_i, !ctrl_i.load);
  assign prod        = hist_sel * coef_sel;
  assign prod_scaled = prod >>> sadpcm_pkg::COEF_SHIFT;
  assign term        = AW'(prod_scaled);

  // Finish pass adds the second term to the partial sum and saturates.
  assign sum = acc_q + term;

  always_comb begin
    if (sum > SAT_MAX) begin
      result_o = 16'sh7fff;
    end else if (sum < SAT_MIN) begin
      result_o = -16'sh8000;
    end else begin
      result_o = sum[sadpcm_pkg::SAMPLE_W-1:0];
    end
  end

  // Partial sum register between the two passes.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= AW'(nib_shifted) + term;
    end
  end

endmodule

/* hdl/spu_adpcm_block_decoder.sv */
// A header byte is taken with no result; a data byte goes through four passes of the shared
// multiplier (S_LO_A, S_LO_B, S_HI_A, S_HI_B) and then the output load in S_OUT.
// The input side stays stalled until S_OUT is left, as the single multiplier is shared.
// The output register lets the next byte in while a finished beat waits to be taken.
// Reset (rst_ni low, asynchronous) clears position, header, history and configuration.
// Depends on sadpcm_pkg and sadpcm_filter_unit.
module spu_adpcm_block_decoder (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Compressed byte stream
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [7:0]                              block_byte_i,
  input  logic                                    restart_i,
  // Decoded sample pairs
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [sadpcm_pkg::SAMPLE_W-1:0]  sample_first_o,
  output logic signed [sadpcm_pkg::SAMPLE_W-1:0]  sample_second_o,
  output logic                                    block_end_o,
  output logic                                    loop_start_here_o,
  output logic [1:0]                              end_action_o,
  output logic                                    bad_filter_o,
  // Configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [sadpcm_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [sadpcm_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [sadpcm_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                    pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO_A,
    S_LO_B,
    S_HI_A,
    S_HI_B,
    S_OUT
  } state_e;

  state_e state_q;

  logic [3:0] pos_q;
  logic [3:0] shift_q;
  logic [3:0] filter_q;
  logic [7:0] flags_q;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0] hist_one_q;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0] hist_two_q;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0] sample_lo_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       output_enable_q;
  logic       ignore_loop_q;
  logic       out_valid_q;

  logic       in_accept;
  logic       out_free;
  logic       cfg_write;
  logic       cfg_idx;
  logic [3:0] pos_eff;
  logic       bad_filter;
  logic [1:0] end_action;
  logic       loop_mark;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0] unit_result;
  sadpcm_pkg::unit_ctrl_t unit_ctrl;

  // Handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Configuration decode; registers sit one word apart.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[sadpcm_pkg::CFG_ADDR_W-1];

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      sadpcm_pkg::CFG_IDX_OUTPUT_ENABLE: prdata[0] = output_enable_q;
      sadpcm_pkg::CFG_IDX_IGNORE_LOOP:   prdata[0] = ignore_loop_q;
      default:                           prdata = '0;
    endcase
  end

  // Sequencer drives the shared unit through two passes per nibble.
  always_comb begin
    unit_ctrl.load   = (state_q == S_LO_A) || (state_q == S_HI_A);
    unit_ctrl.nib_hi = (state_q == S_HI_A) || (state_q == S_HI_B);
  end

  sadpcm_filter_unit u_filter (
    .clk_i      (clk_i),
    .ctrl_i     (unit_ctrl),
    .byte_i     (byte_q),
    .shift_i    (shift_q),
    .filter_i   (filter_q),
    .hist_one_i (hist_one_q),
    .hist_two_i (hist_two_q),
    .result_o   (unit_result)
  );

  // A restart byte always opens a new block.
  assign pos_eff = restart_i ? sadpcm_pkg::POS_HEADER : pos_q;

  // Block status reported with the beat.
  assign bad_filter = (filter_q > sadpcm_pkg::FILTER_MAX);
  assign loop_mark  = last_q && flags_q[sadpcm_pkg::FLAG_LOOP_MARK] && !ignore_loop_q;

  always_comb begin
    end_action = sadpcm_pkg::END_CONTINUE;
    if (last_q && flags_q[sadpcm_pkg::FLAG_END]) begin
      end_action = (flags_q == sadpcm_pkg::FLAGS_LOOP) ? sadpcm_pkg::END_LOOP
                                                       : sadpcm_pkg::END_STOP;
    end
  end

  // State, block context, history and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      pos_q           <= '0;
      shift_q         <= '0;
      filter_q        <= '0;
      flags_q         <= '0;
      hist_one_q      <= '0;
      hist_two_q      <= '0;
      output_enable_q <= 1'b0;
      ignore_loop_q   <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_idx)
          sadpcm_pkg::CFG_IDX_OUTPUT_ENABLE: output_enable_q <= pwdata[0];
          sadpcm_pkg::CFG_IDX_IGNORE_LOOP:   ignore_loop_q   <= pwdata[0];
          default: ;
        endcase
      end

      // The output beat is raised when a result is loaded and dropped once taken.
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            pos_q <= pos_eff + 4'd1;
            if (restart_i) begin
              hist_one_q <= '0;
              hist_two_q <= '0;
            end
            if (pos_eff == sadpcm_pkg::POS_HEADER) begin
              shift_q  <= block_byte_i[3:0];
              filter_q <= block_byte_i[7:4];
            end else if (pos_eff == sadpcm_pkg::POS_FLAGS) begin
              flags_q <= block_byte_i;
            end else begin
              state_q <= S_LO_A;
            end
          end
        end
        S_LO_A: state_q <= S_LO_B;
        S_LO_B: begin
          hist_two_q <= hist_one_q;
          hist_one_q <= unit_result;
          state_q    <= S_HI_A;
        end
        S_HI_A: state_q <= S_HI_B;
        S_HI_B: begin
          hist_two_q <= hist_one_q;
          hist_one_q <= unit_result;
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Byte under decode, the first sample and the output beat.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= block_byte_i;
      last_q <= (pos_eff == sadpcm_pkg::POS_LAST);
    end
    if (state_q == S_LO_B) begin
      sample_lo_q <= unit_result;
    end
    if (state_q == S_OUT && out_free) begin
      sample_first_o    <= output_enable_q ? sample_lo_q : '0;
      sample_second_o   <= output_enable_q ? hist_one_q : '0;
      block_end_o       <= last_q;
      loop_start_here_o <= loop_mark;
      end_action_o      <= end_action;
      bad_filter_o      <= bad_filter;
    end
  end

endmodule

/* hdl/sadpcm_checker.sv */
// Port-level checker for the ADPCM block decoder and the bind that attaches it.
// Depends on sadpcm_pkg and on the ports of spu_adpcm_block_decoder.
module sadpcm_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_stall_o,
  input logic                                    restart_i,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input logic                                    block_end_o,
  input logic                                    loop_start_here_o,
  input logic [1:0]                              end_action_o
);

  // A waiting beat is not withdrawn.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A new beat is loaded only while the input side is held off.
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result loaded while the input side was open");

  // A restart byte is a header byte and does not keep the decoder busy.
  a_header_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && restart_i |=> !in_stall_o)
    else $error("header byte kept the decoder busy");

  // Loop mark and end action are only reported at the end of a block.
  a_end_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !block_end_o |-> !loop_start_here_o &&
      end_action_o == sadpcm_pkg::END_CONTINUE)
    else $error("block status reported before block end");

  // The end action is one of the three defined codes.
  a_end_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> end_action_o == sadpcm_pkg::END_CONTINUE ||
      end_action_o == sadpcm_pkg::END_STOP || end_action_o == sadpcm_pkg::END_LOOP)
    else $error("undefined end action code");

endmodule

bind spu_adpcm_block_decoder sadpcm_checker u_sadpcm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .restart_i         (restart_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .block_end_o       (block_end_o),
  .loop_start_here_o (loop_start_here_o),
  .end_action_o      (end_action_o)
);

/* dv/adpcm_sample_checker.sv */
`timescale 1ns / 1ps
// Checker for the ADPCM block decoder: watches the byte, sample and configuration channels,
// predicts every sample pair beat and compares it. Depends on sadpcm_pkg.
module adpcm_sample_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Byte channel, as seen at the block's ports
  input  logic                                    in_valid_i,
  input  logic                                    in_stall_i,
  input  logic [7:0]                              block_byte_i,
  input  logic                                    restart_i,
  // Sample pair channel
  input  logic                                    out_valid_i,
  input  logic                                    out_stall_i,
  input  logic signed [sadpcm_pkg::SAMPLE_W-1:0]  sample_first_i,
  input  logic signed [sadpcm_pkg::SAMPLE_W-1:0]  sample_second_i,
  input  logic                                    block_end_i,
  input  logic                                    loop_start_here_i,
  input  logic [1:0]                              end_action_i,
  input  logic                                    bad_filter_i,
  // Configuration port
  input  logic                                    psel_i,
  input  logic                                    penable_i,
  input  logic                                    pwrite_i,
  input  logic                                    pready_i,
  input  logic [sadpcm_pkg::CFG_ADDR_W-1:0]       paddr_i,
  input  logic [sadpcm_pkg::CFG_DATA_W-1:0]       pwdata_i,
  // Status for the testbench top
  output int                                      pending_o,
  output int                                      fail_count_o
);

  typedef struct packed {
    logic signed [sadpcm_pkg::SAMPLE_W-1:0] first;
    logic signed [sadpcm_pkg::SAMPLE_W-1:0] second;
    logic                                   blk_end;
    logic                                   loop_here;
    logic [1:0]                             action;
    logic                                   bad;
  } sample_pair_t;

  // Filter weights for the newer and the older history value.
  int coef_newer [0:4] = '{0, 60, 115, 98, 122};
  int coef_older [0:4] = '{0, 0, -52, -55, -60};

  // Predicted decoder state and configuration.
  logic                                   out_enable;
  logic                                   ignore_loop;
  logic [3:0]                             byte_pos;
  logic [3:0]                             shift_amt;
  logic [3:0]                             filter_num;
  logic [7:0]                             blk_flags;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0] hist_newer;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0] hist_older;

  sample_pair_t expected_pairs [$];
  sample_pair_t oldest;
  int           mismatches;

  // One nibble through the shift, the two-tap filter and the saturation.
  function automatic logic signed [sadpcm_pkg::SAMPLE_W-1:0] decode_nibble(
      input logic [3:0] nib, input logic [3:0] shift, input logic [3:0] filter,
      input logic signed [sadpcm_pkg::SAMPLE_W-1:0] newer,
      input logic signed [sadpcm_pkg::SAMPLE_W-1:0] older);
    logic signed [sadpcm_pkg::SAMPLE_W-1:0] raw;
    int base;
    int w_new;
    int w_old;
    int h_new;
    int h_old;
    int acc;
    raw   = {nib, 12'h000};
    base  = raw;
    h_new = newer;
    h_old = older;
    w_new = 0;
    w_old = 0;
    if (filter <= sadpcm_pkg::FILTER_MAX) begin
      w_new = coef_newer[filter];
      w_old = coef_older[filter];
    end
    acc = (base >>> shift) + ((h_new * w_new) >>> sadpcm_pkg::COEF_SHIFT)
          + ((h_old * w_old) >>> sadpcm_pkg::COEF_SHIFT);
    if (acc > 32767) return 16'sh7fff;
    if (acc < -32768) return -16'sh8000;
    return acc[sadpcm_pkg::SAMPLE_W-1:0];
  endfunction

  // Advance the predicted state by one accepted byte; data bytes queue a sample pair.
  task automatic predict_byte(input logic [7:0] b, input logic rs);
    logic [3:0]   cur;
    sample_pair_t beat;
    if (rs) begin
      hist_newer = '0;
      hist_older = '0;
      byte_pos   = sadpcm_pkg::POS_HEADER;
    end
    cur      = byte_pos;
    byte_pos = byte_pos + 4'd1;
    if (cur == sadpcm_pkg::POS_HEADER) begin
      shift_amt  = b[3:0];
      filter_num = b[7:4];
    end else if (cur == sadpcm_pkg::POS_FLAGS) begin
      blk_flags = b;
    end else begin
      beat.first = decode_nibble(b[3:0], shift_amt, filter_num, hist_newer, hist_older);
      hist_older = hist_newer;
      hist_newer = beat.first;
      beat.second = decode_nibble(b[7:4], shift_amt, filter_num, hist_newer, hist_older);
      hist_older = hist_newer;
      hist_newer = beat.second;
      if (!out_enable) begin
        beat.first  = '0;
        beat.second = '0;
      end
      beat.blk_end   = (cur == sadpcm_pkg::POS_LAST);
      beat.loop_here = (cur == sadpcm_pkg::POS_LAST) &&
                       blk_flags[sadpcm_pkg::FLAG_LOOP_MARK] && !ignore_loop;
      if ((cur == sadpcm_pkg::POS_LAST) && blk_flags[sadpcm_pkg::FLAG_END]) begin
        beat.action = (blk_flags == sadpcm_pkg::FLAGS_LOOP) ? sadpcm_pkg::END_LOOP
                                                            : sadpcm_pkg::END_STOP;
      end else begin
        beat.action = sadpcm_pkg::END_CONTINUE;
      end
      beat.bad = (filter_num > sadpcm_pkg::FILTER_MAX);
      expected_pairs.push_back(beat);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare finished beats first, then take in new bytes and register writes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_enable   = 1'b0;
      ignore_loop  = 1'b0;
      byte_pos     = '0;
      shift_amt    = '0;
      filter_num   = '0;
      blk_flags    = '0;
      hist_newer   = '0;
      hist_older   = '0;
      mismatches   = 0;
      expected_pairs.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pairs.size() == 0) begin
          $error("sample pair beat with no expectation waiting");
          mismatches++;
        end else begin
          oldest = expected_pairs.pop_front();
          check_field("sample_first", oldest.first, sample_first_i);
          check_field("sample_second", oldest.second, sample_second_i);
          check_field("block_end", oldest.blk_end, block_end_i);
          check_field("loop_start_here", oldest.loop_here, loop_start_here_i);
          check_field("end_action", oldest.action, end_action_i);
          check_field("bad_filter", oldest.bad, bad_filter_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_byte(block_byte_i, restart_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[sadpcm_pkg::CFG_ADDR_W-1] == sadpcm_pkg::CFG_IDX_IGNORE_LOOP) begin
          ignore_loop = pwdata_i[0];
        end else begin
          out_enable = pwdata_i[0];
        end
      end
      pending_o    <= expected_pairs.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for spu_adpcm_block_decoder: clock, reset, byte stream, receiver stalls and
// register writes. Depends on sadpcm_pkg, the decoder and adpcm_sample_checker.
module tb_top;

  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 154;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 5000;

  logic                                   clk_i;
  logic                                   rst_ni       = 1'b0;
  logic                                   in_valid     = 1'b0;
  logic                                   in_stall;
  logic [7:0]                             block_byte   = '0;
  logic                                   restart      = 1'b0;
  logic                                   out_valid;
  logic                                   out_stall    = 1'b0;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0] sample_first;
  logic signed [sadpcm_pkg::SAMPLE_W-1:0] sample_second;
  logic                                   block_end;
  logic                                   loop_start_here;
  logic [1:0]                             end_action;
  logic                                   bad_filter;
  logic                                   psel         = 1'b0;
  logic                                   penable      = 1'b0;
  logic                                   pwrite       = 1'b0;
  logic [sadpcm_pkg::CFG_ADDR_W-1:0]      paddr        = '0;
  logic [sadpcm_pkg::CFG_DATA_W-1:0]      pwdata       = '0;
  logic [sadpcm_pkg::CFG_DATA_W-1:0]      prdata;
  logic                                   pready;

  int   pending_pairs;
  int   fail_count;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  int   rx_hold_reqs = 0;
  int   rx_hold_seen = 0;
  int   rx_hold_left = 0;
  int   idle_cycles  = 0;
  int   phase_bytes;
  logic [3:0] stream_pos = '0;

  // Opening sequence as {restart, byte}: a saturating block with filter four, the loop mark
  // and a stop, then a wrapped block with a bad filter, the largest shift and the loop flags.
  logic [8:0] opening_seq [0:20] = '{
    9'h140, 9'h007, 9'h077, 9'h077, 9'h077, 9'h077, 9'h088, 9'h088, 9'h088, 9'h088,
    9'h000, 9'h0ff, 9'h00f, 9'h0f0, 9'h080, 9'h008,
    9'h05f, 9'h003, 9'h0ff, 9'h070, 9'h007
  };

  spu_adpcm_block_decoder u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .block_byte_i      (block_byte),
    .restart_i         (restart),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .sample_first_o    (sample_first),
    .sample_second_o   (sample_second),
    .block_end_o       (block_end),
    .loop_start_here_o (loop_start_here),
    .end_action_o      (end_action),
    .bad_filter_o      (bad_filter),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  adpcm_sample_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .block_byte_i      (block_byte),
    .restart_i         (restart),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .sample_first_i    (sample_first),
    .sample_second_i   (sample_second),
    .block_end_i       (block_end),
    .loop_start_here_i (loop_start_here),
    .end_action_i      (end_action),
    .bad_filter_i      (bad_filter),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .pending_o         (pending_pairs),
    .fail_count_o      (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off counted here when a new one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_reqs != rx_hold_seen) begin
        rx_hold_seen = rx_hold_reqs;
        rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Watchdog: too long without any beat moving on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write: setup cycle, then access cycle until pready, then the bus returns to idle.
  task automatic write_reg(input logic idx, input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(sadpcm_pkg::CFG_DATA_W-1){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one byte beat, idling first at the current rate, and hold it until taken.
  task automatic send_byte(input logic [7:0] b, input logic rs);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid   <= 1'b1;
    block_byte <= b;
    restart    <= rs;
    do @(posedge clk_i); while (in_stall);
    stream_pos = rs ? 4'd1 : stream_pos + 4'd1;
    phase_bytes++;
  endtask

  // Stop sending and wait until every predicted pair has arrived, then let the block settle.
  task automatic drain_pairs();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_pairs != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly whole blocks with random content; the rest are broken runs of noise.
  task automatic send_random_block();
    logic [3:0] shift;
    logic [3:0] filter;
    logic [7:0] flags;
    logic       rs;
    int         len;
    if ($urandom_range(99) < 80) begin
      rs     = (stream_pos != sadpcm_pkg::POS_HEADER) || ($urandom_range(3) == 0);
      shift  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 13)) : 4'($urandom_range(12));
      filter = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 5)) : 4'($urandom_range(4));
      flags  = ($urandom_range(9) < 8) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
      send_byte({filter, shift}, rs);
      send_byte(flags, 1'b0);
      for (int i = 0; i < 14; i++) begin
        send_byte(8'($urandom_range(255)), 1'b0);
      end
    end else begin
      len = $urandom_range(15, 1);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)), ($urandom_range(15) == 0));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening with samples visible and loop marks reported.
    write_reg(sadpcm_pkg::CFG_IDX_OUTPUT_ENABLE, 1'b1);
    write_reg(sadpcm_pkg::CFG_IDX_IGNORE_LOOP, 1'b0);
    for (int i = 0; i < 21; i++) begin
      send_byte(opening_seq[i][7:0], opening_seq[i][8]);
    end
    drain_pairs();

    // Random phases, each with its own register settings and idling pattern.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(sadpcm_pkg::CFG_IDX_OUTPUT_ENABLE, (p % 4) != 3);
      write_reg(sadpcm_pkg::CFG_IDX_IGNORE_LOOP, p[0]);
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 62;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 62;
        end
        default: begin
          tx_idle_pct  = 30;
          rx_stall_pct = 30;
        end
      endcase
      // Long receiver hold-off while bytes keep coming, to back the block up.
      if (p == 4) begin
        rx_hold_reqs++;
      end
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        send_random_block();
      end
      drain_pairs();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
